// ===== rtl/core/slcf_pkg.sv =====
// ----------------------------------------------------------------------------
// slcf_pkg
// shared types and constants of the sync word / length / checksum framer
// ----------------------------------------------------------------------------
package slcf_pkg;

  // largest frame accepted, header and trailer included
  localparam int unsigned MAX_FRAME = 4096;

  // frame byte counter, zero while hunting, highest value MAX_FRAME - 1
  localparam int unsigned CNT_W = $clog2(MAX_FRAME);
  // width for frame length compares, covers any length word plus overhead
  localparam int unsigned CMP_W = 18;

  localparam logic [23:0] SYNC_HEAD      = 24'h244249;
  localparam logic [7:0]  SYNC_LAST      = 8'h4E;
  localparam logic [7:0]  BYTE_CR        = 8'h0D;
  localparam logic [7:0]  BYTE_LF        = 8'h0A;
  localparam logic [7:0]  BYTE_MASK      = 8'hFF;
  localparam int unsigned FRAME_OVERHEAD = 12;
  localparam int unsigned PAYLOAD_START  = 8;

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned TDATA_W = 56;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_OVER    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
    logic [15:0]      message_type;
    logic [15:0]      payload_length;
  } result_t;

endpackage

// ===== rtl/core/sync_length_checksum_framer.sv =====
// ----------------------------------------------------------------------------
// sync_length_checksum_framer
// hunts for the "$BIN" sync word, frames by declared length, forwards payload
// bytes and reports checksum and trailer status
// ----------------------------------------------------------------------------
// One byte is taken per request and may be taken in every cycle. Each byte is
// decoded in the cycle it is accepted; a result, if the byte causes one, is
// registered and offered after any older results. A two-entry result buffer
// keeps the input open while a result waits, so the input only stalls when
// two results are held; with the output ready the rate is one byte per cycle.
// Results: kind 0 per payload byte, kind 1 or 2 at the final frame byte, and
// kind 3 at header byte seven when payload length plus 12 exceeds MAX_FRAME.
module sync_length_checksum_framer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // rx_byte
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // payload_byte, payload_index, message_type, payload_length, zero fill
  output logic [slcf_pkg::TDATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]                   m_axis_tuser_o   // kind
);

  logic              in_req;
  logic              res_valid;
  slcf_pkg::result_t res;
  slcf_pkg::result_t head;
  logic              space;

  assign s_axis_tready_o = space;
  assign in_req          = s_axis_tvalid_i && space;

  slcf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_req),
    .in_byte_i   (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  slcf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .head_o      (head)
  );

  assign m_axis_tuser_o = head.kind;
  assign m_axis_tdata_o = {4'd0, head.payload_length, head.message_type,
                           head.payload_index, head.payload_byte};

endmodule

// ===== rtl/core/slcf_core.sv =====
// ----------------------------------------------------------------------------
// slcf_core
// frame state and per-byte decode: sync hunt, header capture, checksum, trailer
// ----------------------------------------------------------------------------
module slcf_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  output logic                res_valid_o,
  output slcf_pkg::result_t   res_o
);

  logic [23:0]                window_q, window_d;
  logic [slcf_pkg::CNT_W-1:0] count_q, count_d;
  logic [15:0]                type_q, type_d;
  logic [15:0]                len_q, len_d;
  logic [15:0]                sum_q, sum_d;
  logic [7:0]                 chk_lo_q, chk_lo_d;
  logic [7:0]                 chk_hi_q, chk_hi_d;
  logic                       cr_q, cr_d;

  logic [slcf_pkg::CMP_W-1:0] pos_ext;
  logic [slcf_pkg::CMP_W-1:0] flen;
  logic [slcf_pkg::CMP_W-1:0] flen_new;
  logic [slcf_pkg::CMP_W-1:0] idx_ext;
  logic                       frame_ok;

  assign pos_ext  = slcf_pkg::CMP_W'(count_q);
  assign flen     = slcf_pkg::CMP_W'(len_q) + slcf_pkg::CMP_W'(slcf_pkg::FRAME_OVERHEAD);
  assign flen_new = slcf_pkg::CMP_W'({in_byte_i, len_q[7:0]})
                  + slcf_pkg::CMP_W'(slcf_pkg::FRAME_OVERHEAD);
  assign idx_ext  = pos_ext - slcf_pkg::CMP_W'(slcf_pkg::PAYLOAD_START);
  assign frame_ok = (chk_lo_q == (sum_q[7:0] & slcf_pkg::BYTE_MASK))
                 && (chk_hi_q == (sum_q[15:8] & slcf_pkg::BYTE_MASK))
                 && cr_q && (in_byte_i == slcf_pkg::BYTE_LF);

  always_comb begin
    window_d    = window_q;
    count_d     = count_q;
    type_d      = type_q;
    len_d       = len_q;
    sum_d       = sum_q;
    chk_lo_d    = chk_lo_q;
    chk_hi_d    = chk_hi_q;
    cr_d        = cr_q;
    res_valid_o = 1'b0;
    res_o.kind           = slcf_pkg::KIND_PAYLOAD;
    res_o.payload_byte   = 8'd0;
    res_o.payload_index  = '0;
    res_o.message_type   = type_q;
    res_o.payload_length = len_q;
    if (in_valid_i) begin
      if (count_q == '0) begin
        window_d = {window_q[15:0], in_byte_i};
        if (window_q == slcf_pkg::SYNC_HEAD && in_byte_i == slcf_pkg::SYNC_LAST) begin
          count_d  = slcf_pkg::CNT_W'(4);
          type_d   = 16'd0;
          len_d    = 16'd0;
          sum_d    = 16'd0;
          chk_lo_d = 8'd0;
          chk_hi_d = 8'd0;
          cr_d     = 1'b0;
        end
      end else begin
        count_d = count_q + slcf_pkg::CNT_W'(1);
        if (pos_ext < slcf_pkg::CMP_W'(slcf_pkg::PAYLOAD_START)) begin
          // header positions four to seven
          unique case (count_q[1:0])
            2'd0: type_d[7:0]  = in_byte_i;
            2'd1: type_d[15:8] = in_byte_i;
            2'd2: len_d[7:0]   = in_byte_i;
            default: begin
              len_d[15:8] = in_byte_i;
              if (flen_new > slcf_pkg::CMP_W'(slcf_pkg::MAX_FRAME)) begin
                count_d              = '0;
                res_valid_o          = 1'b1;
                res_o.kind           = slcf_pkg::KIND_OVER;
                res_o.payload_length = {in_byte_i, len_q[7:0]};
              end
            end
          endcase
        end else if (pos_ext + slcf_pkg::CMP_W'(4) < flen) begin
          sum_d               = sum_q + 16'(in_byte_i);
          res_valid_o         = 1'b1;
          res_o.payload_byte  = in_byte_i;
          res_o.payload_index = idx_ext[slcf_pkg::IDX_W-1:0];
        end else if (pos_ext + slcf_pkg::CMP_W'(4) == flen) begin
          chk_lo_d = in_byte_i;
        end else if (pos_ext + slcf_pkg::CMP_W'(3) == flen) begin
          chk_hi_d = in_byte_i;
        end else if (pos_ext + slcf_pkg::CMP_W'(2) == flen) begin
          cr_d = (in_byte_i == slcf_pkg::BYTE_CR);
        end else begin
          // last byte of the frame
          count_d     = '0;
          res_valid_o = 1'b1;
          res_o.kind  = frame_ok ? slcf_pkg::KIND_GOOD : slcf_pkg::KIND_BAD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      count_q  <= '0;
      type_q   <= '0;
      len_q    <= '0;
      sum_q    <= '0;
      chk_lo_q <= '0;
      chk_hi_q <= '0;
      cr_q     <= 1'b0;
    end else begin
      window_q <= window_d;
      count_q  <= count_d;
      type_q   <= type_d;
      len_q    <= len_d;
      sum_q    <= sum_d;
      chk_lo_q <= chk_lo_d;
      chk_hi_q <= chk_hi_d;
      cr_q     <= cr_d;
    end
  end

  a_res_needs_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> in_valid_i)
    else $error("result without an input request");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> count_q >= slcf_pkg::CNT_W'(4))
    else $error("frame counter in the sync word range");

  a_end_hunts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind != slcf_pkg::KIND_PAYLOAD |=> count_q == '0)
    else $error("frame status without return to hunting");

endmodule

// ===== rtl/core/slcf_out_buf.sv =====
// ----------------------------------------------------------------------------
// slcf_out_buf
// two-entry result register between the framer core and the output stream
// ----------------------------------------------------------------------------
module slcf_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  slcf_pkg::result_t push_data_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              ready_i,
  output slcf_pkg::result_t head_o
);

  slcf_pkg::result_t head_q, head_d;
  slcf_pkg::result_t tail_q, tail_d;
  logic [1:0]        count_q, count_d;
  logic              pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign space_o = (count_q != 2'd2);
  assign head_o  = head_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    unique case ({push_i, pop})
      2'b10: begin
        if (count_q == 2'd0) begin
          head_d = push_data_i;
        end else begin
          tail_d = push_data_i;
        end
        count_d = count_q + 2'd1;
      end
      2'b01: begin
        head_d  = tail_q;
        count_d = count_q - 2'd1;
      end
      2'b11: begin
        if (count_q == 2'd1) begin
          head_d = push_data_i;
        end else begin
          head_d = tail_q;
          tail_d = push_data_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer overfilled");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != 2'd2)
    else $error("result pushed into a full buffer");

  a_tail_moves_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd2 && pop |=> head_q == $past(tail_q))
    else $error("buffered result lost on pop");

endmodule

// ===== tb/sv/framer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framer_checker
// decodes every accepted input byte with its own frame state, queues the
// expected results and compares each accepted output result in order
// ----------------------------------------------------------------------------
module framer_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [7:0]                   in_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [slcf_pkg::TDATA_W-1:0] out_data_i,
  input  logic [1:0]                   out_kind_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  slcf_pkg::result_t frame_results[$];
  int                fail_count;

  logic [23:0] window_q;
  int unsigned frame_pos;
  logic [15:0] type_q;
  logic [15:0] length_q;
  logic [15:0] sum_q;
  logic [7:0]  sum_lo_rx;
  logic [7:0]  sum_hi_rx;
  logic        cr_ok;

  task automatic queue_result(input slcf_pkg::kind_e kind, input logic [7:0] b,
                              input int unsigned idx);
    slcf_pkg::result_t r;
    r.kind           = kind;
    r.payload_byte   = b;
    r.payload_index  = idx[slcf_pkg::IDX_W-1:0];
    r.message_type   = type_q;
    r.payload_length = length_q;
    frame_results.push_back(r);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic        hit;
    logic        good;
    int unsigned pos;
    int unsigned flen;
    if (frame_pos == 0) begin
      hit      = (window_q == slcf_pkg::SYNC_HEAD) && (b == slcf_pkg::SYNC_LAST);
      window_q = {window_q[15:0], b};
      if (hit) begin
        frame_pos = 4;
        type_q    = '0;
        length_q  = '0;
        sum_q     = '0;
        sum_lo_rx = '0;
        sum_hi_rx = '0;
        cr_ok     = 1'b0;
      end
      return;
    end
    pos       = frame_pos;
    frame_pos = pos + 1;
    if (pos < slcf_pkg::PAYLOAD_START) begin
      case (pos)
        4: type_q[7:0]    = b;
        5: type_q[15:8]   = b;
        6: length_q[7:0]  = b;
        default: begin
          length_q[15:8] = b;
          if (32'(length_q) + slcf_pkg::FRAME_OVERHEAD > slcf_pkg::MAX_FRAME) begin
            frame_pos = 0;
            queue_result(slcf_pkg::KIND_OVER, 8'h00, 0);
          end
        end
      endcase
      return;
    end
    flen = 32'(length_q) + slcf_pkg::FRAME_OVERHEAD;
    if (pos + 4 < flen) begin
      sum_q = sum_q + 16'(b);
      queue_result(slcf_pkg::KIND_PAYLOAD, b, pos - slcf_pkg::PAYLOAD_START);
    end else if (pos + 4 == flen) begin
      sum_lo_rx = b;
    end else if (pos + 3 == flen) begin
      sum_hi_rx = b;
    end else if (pos + 2 == flen) begin
      cr_ok = (b == slcf_pkg::BYTE_CR);
    end else begin
      frame_pos = 0;
      good = (sum_lo_rx == sum_q[7:0]) && (sum_hi_rx == sum_q[15:8]) && cr_ok &&
             (b == slcf_pkg::BYTE_LF);
      queue_result(good ? slcf_pkg::KIND_GOOD : slcf_pkg::KIND_BAD, 8'h00, 0);
    end
  endtask

  task automatic check_result();
    slcf_pkg::result_t exp_r;
    logic [7:0]        got_byte;
    logic [11:0]       got_idx;
    logic [15:0]       got_type;
    logic [15:0]       got_len;
    got_byte = out_data_i[7:0];
    got_idx  = out_data_i[19:8];
    got_type = out_data_i[35:20];
    got_len  = out_data_i[51:36];
    if (frame_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: kind %0d byte %02h index %0d type %04h length %04h",
                 out_kind_i, got_byte, got_idx, got_type, got_len);
      return;
    end
    exp_r = frame_results.pop_front();
    if (out_kind_i !== exp_r.kind || got_byte !== exp_r.payload_byte ||
        got_idx !== exp_r.payload_index || got_type !== exp_r.message_type ||
        got_len !== exp_r.payload_length) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch at %0t: expected kind %0d byte %02h index %0d type %04h length %04h",
                 $realtime, exp_r.kind, exp_r.payload_byte, exp_r.payload_index,
                 exp_r.message_type, exp_r.payload_length);
        $display("  actual kind %0d byte %02h index %0d type %04h length %04h",
                 out_kind_i, got_byte, got_idx, got_type, got_len);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  = '0;
      frame_pos = 0;
      type_q    = '0;
      length_q  = '0;
      sum_q     = '0;
      sum_lo_rx = '0;
      sum_hi_rx = '0;
      cr_ok     = 1'b0;
      fail_count = 0;
      frame_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // older results leave before this edge's byte is decoded
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) decode_byte(in_byte_i);
      fail_count_o <= fail_count;
      pending_o    <= frame_results.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the framer: good, flawed, over-long and cut frames and noise,
// with random idling on both streams and one long output hold
// ----------------------------------------------------------------------------
module tb;

  typedef enum int {
    FLAW_NONE,
    FLAW_SUM_LO,
    FLAW_SUM_HI,
    FLAW_CR,
    FLAW_LF,
    FLAW_CUT
  } flaw_e;

  localparam int ITEMS       = 1350;
  localparam int CALM_ITEMS  = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;

  logic                         clk_i   = 1'b0;
  logic                         rst_ni  = 1'b0;
  logic                         s_valid = 1'b0;
  logic [7:0]                   s_data  = 8'h00;
  logic                         m_ready = 1'b0;
  logic                         s_ready;
  logic                         m_valid;
  logic [slcf_pkg::TDATA_W-1:0] m_data;
  logic [1:0]                   m_user;
  int                           fail_count;
  int                           pending;

  int sent        = 0;
  bit calm        = 1'b0;
  bit idle_on     = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_issued = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sync_length_checksum_framer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  framer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_byte_i    (s_data),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .out_kind_i   (m_user),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  task automatic send_byte(input logic [7:0] b);
    idle_on = !calm && ((sent / 150) % 3 != 2);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    do @(posedge clk_i); while (!s_ready);
    sent++;
  endtask

  task automatic send_noise(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      // partial sync word that breaks off before the last byte
      if ($urandom_range(0, 7) == 0) begin
        send_byte(slcf_pkg::SYNC_HEAD[23:16]);
        send_byte(slcf_pkg::SYNC_HEAD[15:8]);
        send_byte(slcf_pkg::SYNC_HEAD[7:0]);
        b = 8'($urandom_range(0, 255));
        if (b == slcf_pkg::SYNC_LAST) b = 8'h00;
        send_byte(b);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic send_frame(input logic [15:0] mtype, input logic [15:0] plen,
                            input flaw_e flaw);
    logic [15:0] sum;
    logic [7:0]  b;
    logic [7:0]  flip;
    int unsigned n_payload;
    sum  = '0;
    flip = 8'($urandom_range(1, 255));
    send_byte(slcf_pkg::SYNC_HEAD[23:16]);
    send_byte(slcf_pkg::SYNC_HEAD[15:8]);
    send_byte(slcf_pkg::SYNC_HEAD[7:0]);
    send_byte(slcf_pkg::SYNC_LAST);
    send_byte(mtype[7:0]);
    send_byte(mtype[15:8]);
    send_byte(plen[7:0]);
    send_byte(plen[15:8]);
    if (32'(plen) + slcf_pkg::FRAME_OVERHEAD > slcf_pkg::MAX_FRAME) return;
    n_payload = (flaw == FLAW_CUT) ? $urandom_range(0, plen) : plen;
    for (int unsigned i = 0; i < n_payload; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'hFF;
        1:       b = 8'h00;
        default: b = 8'($urandom_range(0, 255));
      endcase
      sum = sum + 16'(b);
      send_byte(b);
    end
    if (flaw == FLAW_CUT) return;
    send_byte(sum[7:0] ^ ((flaw == FLAW_SUM_LO) ? flip : 8'h00));
    send_byte(sum[15:8] ^ ((flaw == FLAW_SUM_HI) ? flip : 8'h00));
    send_byte(slcf_pkg::BYTE_CR ^ ((flaw == FLAW_CR) ? flip : 8'h00));
    send_byte(slcf_pkg::BYTE_LF ^ ((flaw == FLAW_LF) ? flip : 8'h00));
  endtask

  initial begin : receiver
    int run_len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      m_ready <= 1'b1;
      run_len = $urandom_range(1, 30);
      repeat (run_len) @(posedge clk_i);
      if (idle_on) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int          pick;
    int          waited;
    logic [15:0] mtype;
    logic [15:0] plen;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // over-long frame with all-ones header words, then an empty good frame
    send_frame(16'hFFFF, 16'hFFFF, FLAW_NONE);
    send_frame(16'h0000, 16'h0000, FLAW_NONE);

    while (sent < ITEMS) begin
      calm  = (sent >= ITEMS - CALM_ITEMS);
      mtype = 16'($urandom_range(0, 65535));
      if (!hold_issued && sent >= 500) begin
        hold_issued = 1'b1;
        hold_req    = 1'b1;
        send_frame(mtype, 16'd80, FLAW_NONE);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          send_frame(mtype, 16'($urandom_range(0, 24)), FLAW_NONE);
        end else if (pick < 76) begin
          send_frame(mtype, 16'($urandom_range(0, 24)),
                     flaw_e'($urandom_range(int'(FLAW_SUM_LO), int'(FLAW_LF))));
        end else if (pick < 84) begin
          if ($urandom_range(0, 2) == 0) begin
            plen = 16'(slcf_pkg::MAX_FRAME - slcf_pkg::FRAME_OVERHEAD + 1);
          end else begin
            plen = 16'($urandom_range(slcf_pkg::MAX_FRAME - slcf_pkg::FRAME_OVERHEAD + 1,
                                      65535));
          end
          send_frame(mtype, plen, FLAW_NONE);
        end else if (pick < 92) begin
          send_noise($urandom_range(1, 8));
        end else if (pick < 96) begin
          send_frame(mtype, 16'($urandom_range(1, 16)), FLAW_CUT);
        end else begin
          send_frame(mtype, 16'($urandom_range(25, 300)), FLAW_NONE);
        end
      end
    end
    s_valid <= 1'b0;

    repeat (2) @(posedge clk_i);
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sync_length_checksum_framer.f =====
rtl/core/slcf_pkg.sv
rtl/core/slcf_core.sv
rtl/core/slcf_out_buf.sv
rtl/core/sync_length_checksum_framer.sv
tb/sv/framer_checker.sv
tb/sv/tb.sv
